@@ hdl/adsr_pkg.sv @@
// Shared types, codes and microcode program of the ADSR envelope step block.
package adsr_pkg;

  localparam int CMD_W = 2;
  localparam int VOL_W = 16;
  localparam int ENV_GAIN_W = 16;
  localparam int STAGE_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int UPC_W = 4;
  localparam int OP_W = 4;
  localparam int COND_W = 3;

  // Commands
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NOTE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  // Envelope stages
  localparam logic [STAGE_W-1:0] ST_ATTACK  = 2'd0;
  localparam logic [STAGE_W-1:0] ST_DECAY   = 2'd1;
  localparam logic [STAGE_W-1:0] ST_SUSTAIN = 2'd2;
  localparam logic [STAGE_W-1:0] ST_RELEASE = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_FACTOR = 2'd3;

  // Register reset values, Q0.16
  localparam logic [31:0] ATTACK_STEP_RST    = 32'd655;
  localparam logic [31:0] DECAY_FACTOR_RST   = 32'd62259;
  localparam logic [31:0] SUSTAIN_LEVEL_RST  = 32'd49152;
  localparam logic [31:0] RELEASE_FACTOR_RST = 32'd62259;

  // Datapath micro-operations
  localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
  localparam logic [OP_W-1:0] OP_CMD       = 4'd1;
  localparam logic [OP_W-1:0] OP_FORCE_REL = 4'd2;
  localparam logic [OP_W-1:0] OP_REL_MUL   = 4'd3;
  localparam logic [OP_W-1:0] OP_REL_FIN   = 4'd4;
  localparam logic [OP_W-1:0] OP_ATT_MUL   = 4'd5;
  localparam logic [OP_W-1:0] OP_ATT_FIN   = 4'd6;
  localparam logic [OP_W-1:0] OP_DEC_GOAL  = 4'd7;
  localparam logic [OP_W-1:0] OP_DEC_CMP   = 4'd8;
  localparam logic [OP_W-1:0] OP_DEC_MUL   = 4'd9;
  localparam logic [OP_W-1:0] OP_DEC_FIN   = 4'd10;
  localparam logic [OP_W-1:0] OP_EMIT      = 4'd11;

  // Branch conditions
  localparam logic [COND_W-1:0] CND_NEVER      = 3'd0;
  localparam logic [COND_W-1:0] CND_ALWAYS     = 3'd1;
  localparam logic [COND_W-1:0] CND_NOTE       = 3'd2;
  localparam logic [COND_W-1:0] CND_IDLE_VOICE = 3'd3;
  localparam logic [COND_W-1:0] CND_ST_ATTACK  = 3'd4;
  localparam logic [COND_W-1:0] CND_ST_DECAY   = 3'd5;
  localparam logic [COND_W-1:0] CND_ST_SUSTAIN = 3'd6;
  localparam logic [COND_W-1:0] CND_GAIN_LE    = 3'd7;

  // Program addresses
  localparam logic [UPC_W-1:0] A_CMD       = 4'd0;
  localparam logic [UPC_W-1:0] A_ACT_CHK   = 4'd1;
  localparam logic [UPC_W-1:0] A_FORCE_REL = 4'd2;
  localparam logic [UPC_W-1:0] A_DISP_ATT  = 4'd3;
  localparam logic [UPC_W-1:0] A_DISP_DEC  = 4'd4;
  localparam logic [UPC_W-1:0] A_DISP_SUS  = 4'd5;
  localparam logic [UPC_W-1:0] A_REL_MUL   = 4'd6;
  localparam logic [UPC_W-1:0] A_REL_FIN   = 4'd7;
  localparam logic [UPC_W-1:0] A_ATT_MUL   = 4'd8;
  localparam logic [UPC_W-1:0] A_ATT_FIN   = 4'd9;
  localparam logic [UPC_W-1:0] A_DEC_GOAL  = 4'd10;
  localparam logic [UPC_W-1:0] A_DEC_CMP   = 4'd11;
  localparam logic [UPC_W-1:0] A_DEC_MUL   = 4'd12;
  localparam logic [UPC_W-1:0] A_DEC_FIN   = 4'd13;
  localparam logic [UPC_W-1:0] A_END       = 4'd14;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [UPC_W-1:0]  target;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    logic            load;
    logic            en;
    logic [OP_W-1:0] op;
  } ctl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic               note;
    logic               active;
    logic [STAGE_W-1:0] stage;
    logic               gain_le_goal;
    logic               out_free;
  } sts_t;

  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] addr);
    uword_t w;
    w = '{op: OP_NOP, cond: CND_NEVER, target: A_END};
    case (addr)
      A_CMD:       w = '{op: OP_CMD,       cond: CND_NOTE,       target: A_END};
      A_ACT_CHK:   w = '{op: OP_NOP,       cond: CND_IDLE_VOICE, target: A_END};
      A_FORCE_REL: w = '{op: OP_FORCE_REL, cond: CND_NEVER,      target: A_END};
      A_DISP_ATT:  w = '{op: OP_NOP,       cond: CND_ST_ATTACK,  target: A_ATT_MUL};
      A_DISP_DEC:  w = '{op: OP_NOP,       cond: CND_ST_DECAY,   target: A_DEC_GOAL};
      A_DISP_SUS:  w = '{op: OP_NOP,       cond: CND_ST_SUSTAIN, target: A_END};
      A_REL_MUL:   w = '{op: OP_REL_MUL,   cond: CND_NEVER,      target: A_END};
      A_REL_FIN:   w = '{op: OP_REL_FIN,   cond: CND_ALWAYS,     target: A_END};
      A_ATT_MUL:   w = '{op: OP_ATT_MUL,   cond: CND_NEVER,      target: A_END};
      A_ATT_FIN:   w = '{op: OP_ATT_FIN,   cond: CND_ALWAYS,     target: A_END};
      A_DEC_GOAL:  w = '{op: OP_DEC_GOAL,  cond: CND_NEVER,      target: A_END};
      A_DEC_CMP:   w = '{op: OP_DEC_CMP,   cond: CND_GAIN_LE,    target: A_END};
      A_DEC_MUL:   w = '{op: OP_DEC_MUL,   cond: CND_NEVER,      target: A_END};
      A_DEC_FIN:   w = '{op: OP_DEC_FIN,   cond: CND_ALWAYS,     target: A_END};
      A_END:       w = '{op: OP_EMIT,      cond: CND_NEVER,      target: A_END};
      default:     w = '{op: OP_EMIT,      cond: CND_NEVER,      target: A_END};
    endcase
    return w;
  endfunction

endpackage

@@ hdl/adsr_in_if.sv @@
// Input channel: envelope commands with valid/ready handshake.
interface adsr_in_if import adsr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [VOL_W-1:0] note_volume;

  modport source (output valid, output cmd, output note_volume, input ready);
  modport sink (input valid, input cmd, input note_volume, output ready);
endinterface

@@ hdl/adsr_out_if.sv @@
// Result channel: envelope gain, stage and activity with valid/ready handshake.
interface adsr_out_if import adsr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ENV_GAIN_W-1:0] env_gain;
  logic [STAGE_W-1:0]    env_stage;
  logic                  voice_active;

  modport source (output valid, output env_gain, output env_stage, output voice_active,
                  input ready);
  modport sink (input valid, input env_gain, input env_stage, input voice_active,
                output ready);
endinterface

@@ hdl/adsr_useq.sv @@
// Microcode sequencer: step counter, program fetch and conditional jumps.
module adsr_useq import adsr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  logic             busy_r, busy_nxt;
  logic [UPC_W-1:0] upc_r, upc_nxt;
  uword_t           word;
  logic             stall;
  logic             take;

  always_comb begin
    word  = ucode_rom(upc_r);
    stall = (word.op == OP_EMIT) && !sts.out_free;
    case (word.cond)
      CND_NEVER:      take = 1'b0;
      CND_ALWAYS:     take = 1'b1;
      CND_NOTE:       take = sts.note;
      CND_IDLE_VOICE: take = !sts.active;
      CND_ST_ATTACK:  take = (sts.stage == ST_ATTACK);
      CND_ST_DECAY:   take = (sts.stage == ST_DECAY);
      CND_ST_SUSTAIN: take = (sts.stage == ST_SUSTAIN);
      CND_GAIN_LE:    take = sts.gain_le_goal;
      default:        take = 1'b0;
    endcase
  end

  assign in_ready = !busy_r;
  assign ctl.load = in_valid && !busy_r;
  assign ctl.en   = busy_r && !stall;
  assign ctl.op   = word.op;

  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    if (!busy_r) begin
      if (in_valid) begin
        busy_nxt = 1'b1;
        upc_nxt  = A_CMD;
      end
    end else if (!stall) begin
      if (word.op == OP_EMIT) begin
        busy_nxt = 1'b0;
      end else if (take) begin
        upc_nxt = word.target;
      end else begin
        upc_nxt = upc_r + UPC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= A_CMD;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
    end
  end

endmodule

@@ hdl/adsr_dpath.sv @@
// Envelope datapath: config registers, voice state, shared multiplier, result register.
module adsr_dpath import adsr_pkg::*; #(
  parameter int GAIN_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_BITS-1:0] cfg_wdata,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [VOL_W-1:0]     in_note_volume,
  input  ctl_t                 ctl,
  output sts_t                 sts,
  adsr_out_if.source           out_ch
);

  localparam int unsigned EPS = ((32'd1 << GAIN_BITS) + 32'd50) / 32'd100;
  localparam logic [GAIN_BITS-1:0] EPS_G = GAIN_BITS'(EPS);

  logic [GAIN_BITS-1:0] att_step_r, dec_fac_r, sus_lvl_r, rel_fac_r;

  logic [CMD_W-1:0]     cmd_r;
  logic [GAIN_BITS-1:0] vol_in_r;

  logic [GAIN_BITS-1:0] gain_r, gain_nxt;
  logic [GAIN_BITS-1:0] vol_r, vol_nxt;
  logic [STAGE_W-1:0]   stage_r, stage_nxt;
  logic                 rel_r, rel_nxt;
  logic                 act_r, act_nxt;
  logic [GAIN_BITS-1:0] goal_r;
  logic [GAIN_BITS-1:0] prod_r;

  logic [GAIN_BITS-1:0]   mul_a, mul_b;
  logic [2*GAIN_BITS-1:0] product;
  logic                   mul_load;
  logic [GAIN_BITS:0]     att_sum;
  logic                   emit;

  logic                  out_valid_r, out_valid_nxt;
  logic [ENV_GAIN_W-1:0] out_gain_r;
  logic [STAGE_W-1:0]    out_stage_r;
  logic                  out_act_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      att_step_r <= GAIN_BITS'(ATTACK_STEP_RST);
      dec_fac_r  <= GAIN_BITS'(DECAY_FACTOR_RST);
      sus_lvl_r  <= GAIN_BITS'(SUSTAIN_LEVEL_RST);
      rel_fac_r  <= GAIN_BITS'(RELEASE_FACTOR_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATTACK_STEP:    att_step_r <= cfg_wdata;
        CFG_DECAY_FACTOR:   dec_fac_r  <= cfg_wdata;
        CFG_SUSTAIN_LEVEL:  sus_lvl_r  <= cfg_wdata;
        CFG_RELEASE_FACTOR: rel_fac_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Latch the accepted beat
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r    <= in_cmd;
      vol_in_r <= GAIN_BITS'(in_note_volume);
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_load = 1'b0;
    case (ctl.op)
      OP_REL_MUL: begin
        mul_a = gain_r;          mul_b = rel_fac_r; mul_load = ctl.en;
      end
      OP_ATT_MUL: begin
        mul_a = att_step_r;      mul_b = vol_r;     mul_load = ctl.en;
      end
      OP_DEC_GOAL: begin
        mul_a = sus_lvl_r;       mul_b = vol_r;     mul_load = ctl.en;
      end
      OP_DEC_MUL: begin
        mul_a = gain_r - goal_r; mul_b = dec_fac_r; mul_load = ctl.en;
      end
      default: ;
    endcase
  end

  assign product = {{GAIN_BITS{1'b0}}, mul_a} * {{GAIN_BITS{1'b0}}, mul_b};
  assign att_sum = {1'b0, gain_r} + {1'b0, prod_r};

  always_ff @(posedge clk) begin
    if (mul_load) begin
      prod_r <= product[2*GAIN_BITS-1:GAIN_BITS];
    end
    if (ctl.en && ctl.op == OP_DEC_CMP) begin
      goal_r <= prod_r;
    end
  end

  // Voice state update
  always_comb begin
    gain_nxt  = gain_r;
    vol_nxt   = vol_r;
    stage_nxt = stage_r;
    rel_nxt   = rel_r;
    act_nxt   = act_r;
    if (ctl.en) begin
      case (ctl.op)
        OP_CMD: begin
          if (cmd_r == CMD_NOTE) begin
            vol_nxt   = vol_in_r;
            gain_nxt  = '0;
            stage_nxt = ST_ATTACK;
            rel_nxt   = 1'b0;
            act_nxt   = 1'b1;
          end else if (cmd_r == CMD_RELEASE) begin
            rel_nxt = 1'b1;
          end
        end
        OP_FORCE_REL: begin
          if (rel_r) begin
            stage_nxt = ST_RELEASE;
          end
        end
        OP_REL_FIN: begin
          if (prod_r < EPS_G) begin
            gain_nxt = '0;
            act_nxt  = 1'b0;
          end else begin
            gain_nxt = prod_r;
          end
        end
        OP_ATT_FIN: begin
          if (att_sum >= {1'b0, vol_r}) begin
            gain_nxt  = vol_r;
            stage_nxt = ST_DECAY;
          end else begin
            gain_nxt = att_sum[GAIN_BITS-1:0];
          end
        end
        OP_DEC_CMP: begin
          if (gain_r <= prod_r) begin
            gain_nxt  = prod_r;
            stage_nxt = ST_SUSTAIN;
          end
        end
        OP_DEC_FIN: begin
          if (prod_r < EPS_G) begin
            gain_nxt  = goal_r;
            stage_nxt = ST_SUSTAIN;
          end else begin
            gain_nxt = goal_r + prod_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= '0;
      vol_r   <= '0;
      stage_r <= ST_ATTACK;
      rel_r   <= 1'b0;
      act_r   <= 1'b0;
    end else begin
      gain_r  <= gain_nxt;
      vol_r   <= vol_nxt;
      stage_r <= stage_nxt;
      rel_r   <= rel_nxt;
      act_r   <= act_nxt;
    end
  end

  // Result register
  assign emit = ctl.en && (ctl.op == OP_EMIT);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_gain_r  <= ENV_GAIN_W'(gain_r);
      out_stage_r <= stage_r;
      out_act_r   <= act_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.env_gain     = out_gain_r;
  assign out_ch.env_stage    = out_stage_r;
  assign out_ch.voice_active = out_act_r;

  assign sts.note         = (cmd_r == CMD_NOTE);
  assign sts.active       = act_r;
  assign sts.stage        = stage_r;
  assign sts.gain_le_goal = (gain_r <= prod_r);
  assign sts.out_free     = !out_valid_r || out_ch.ready;

endmodule

@@ hdl/adsr_envelope_step.sv @@
// Top level of the single-voice ADSR envelope step block.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+------------------------------------------
//   in_ch    | in  | valid/ready       | cmd[1:0], note_volume[15:0]
//   out_ch   | out | valid/ready       | env_gain[15:0], env_stage[1:0], voice_active
//   cfg      | in  | cfg_we (no wait)  | cfg_index[1:0], cfg_wdata[GAIN_BITS-1:0]
//
// Each beat runs a short microcode program: 2 steps for a note start, 3 for a
// tick on a silent voice, up to 10 steps for a decay tick (goal multiply, compare,
// distance multiply, finish). in_ch.ready stays low while a program runs, so a new
// beat is taken only once the previous one has finished.
// The one shared multiplier, registered after each use, sets the step count.
// The result sits in an output register; the final step stalls only while that
// register still holds a beat that out_ch has not taken.
// Reset is synchronous, active low; it restores the register defaults and a silent voice.
module adsr_envelope_step import adsr_pkg::*; #(
  parameter int GAIN_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_BITS-1:0] cfg_wdata,
  adsr_in_if.sink              in_ch,
  adsr_out_if.source           out_ch
);

  ctl_t ctl;
  sts_t sts;
  logic seq_ready;

  // Sequencer: fetch control words, advance or jump
  adsr_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (seq_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  assign in_ch.ready = seq_ready;

  // Datapath: hold voice state, run the multiplier, drive the result beat
  adsr_dpath #(
    .GAIN_BITS (GAIN_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_cmd         (in_ch.cmd),
    .in_note_volume (in_ch.note_volume),
    .ctl            (ctl),
    .sts            (sts),
    .out_ch         (out_ch)
  );

  // A new result beat appears only as the sequencer finishes its program.
  a_emit_ends_program: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $rose(in_ch.ready))
    else $error("result beat raised without sequencer completing");

  // A voice that has gone silent always reports zero gain.
  a_silent_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.voice_active) |-> (out_ch.env_gain == '0))
    else $error("inactive voice with nonzero gain");

  // An accepted beat keeps the sequencer busy for at least one step.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("sequencer ready right after accept");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the single-voice ADSR envelope step block.
module tb_top;
  import adsr_pkg::*;

  // Command code the block does not define; it must behave as a plain tick.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Gain floor of the release stage and of the decay snap: 0.01 in Q0.16.
  localparam logic [15:0] GAIN_EPS = 16'(((1 << 16) + 50) / 100);

  localparam int RAND_PHASES   = 8;
  localparam int PHASE_BEATS   = 108;
  localparam int SETTLE_CYCLES = 16;    // well past the longest program
  localparam int LONG_HOLD     = 300;
  localparam int MAX_REPORTS   = 40;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [VOL_W-1:0] volume;
  } env_cmd_t;

  typedef struct packed {
    logic [ENV_GAIN_W-1:0] gain;
    logic [STAGE_W-1:0]    stage;
    logic                  active;
  } env_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_wdata;

  adsr_in_if  in_ch ();
  adsr_out_if out_ch ();

  adsr_envelope_step #(.GAIN_BITS(16)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Commands waiting to be offered, and envelope results still owed by the block.
  env_cmd_t    pending_cmds[$];
  env_result_t results_due[$];

  int unsigned cmds_queued   = 0;
  int unsigned beats_taken   = 0;
  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned notes_started = 0;
  int unsigned releases_sent = 0;
  int unsigned voices_ended  = 0;
  int unsigned settings_used = 1;
  int unsigned stage_hits[4] = '{default: 0};

  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;
  int unsigned in_gap  = 0;
  int unsigned out_gap = 0;
  logic        in_beat_taken = 1'b0;
  logic        long_hold     = 1'b0;
  logic        squeeze_go    = 1'b0;

  // Envelope model state and its copy of the registers.
  logic [15:0]        env_gain;
  logic [STAGE_W-1:0] env_stage;
  logic [15:0]        env_volume;
  logic               env_released;
  logic               env_active;
  logic [15:0]        attack_step, decay_factor, sustain_level, release_factor;

  // Q0.16 product, truncated to the high half.
  function automatic logic [15:0] qmul(logic [15:0] a, logic [15:0] b);
    logic [31:0] prod;
    prod = {16'd0, a} * {16'd0, b};
    return prod[31:16];
  endfunction

  function automatic logic [15:0] pick_setting(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < MAX_REPORTS)
      $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Apply one command beat to the envelope model and queue the result it owes.
  task automatic advance_envelope(logic [CMD_W-1:0] cmd, logic [15:0] volume);
    logic [16:0] sum;
    logic [15:0] goal;
    logic [15:0] shrink;
    env_result_t owed;
    if (cmd == CMD_NOTE) begin
      env_volume   = volume;
      env_gain     = 16'd0;
      env_stage    = ST_ATTACK;
      env_released = 1'b0;
      env_active   = 1'b1;
      notes_started++;
    end else begin
      if (cmd == CMD_RELEASE) begin
        env_released = 1'b1;
        releases_sent++;
      end
      // A silent voice ignores the tick entirely.
      if (env_active) begin
        if (env_released)
          env_stage = ST_RELEASE;
        case (env_stage)
          ST_ATTACK: begin
            sum = {1'b0, env_gain} + {1'b0, qmul(attack_step, env_volume)};
            if (sum >= {1'b0, env_volume}) begin
              env_gain  = env_volume;
              env_stage = ST_DECAY;
            end else begin
              env_gain = sum[15:0];
            end
          end
          ST_DECAY: begin
            goal = qmul(sustain_level, env_volume);
            if (env_gain <= goal) begin
              // Already at or under the goal, e.g. after sustain was raised.
              env_gain  = goal;
              env_stage = ST_SUSTAIN;
            end else begin
              shrink = qmul(env_gain - goal, decay_factor);
              if (shrink < GAIN_EPS) begin
                env_gain  = goal;
                env_stage = ST_SUSTAIN;
              end else begin
                env_gain = goal + shrink;
              end
            end
          end
          ST_SUSTAIN: ;
          default: begin
            env_gain = qmul(env_gain, release_factor);
            if (env_gain < GAIN_EPS) begin
              env_gain   = 16'd0;
              env_active = 1'b0;
              voices_ended++;
            end
          end
        endcase
      end
    end
    owed = '{gain: env_gain, stage: env_stage, active: env_active};
    results_due = {results_due, owed};
  endtask

  // Sample both channels and the register port at the rising edge; the model
  // follows every register write and every accepted command beat.
  always @(posedge clk) begin : check_beats
    env_result_t got;
    env_result_t want;
    if (!rst_n) begin
      env_gain       = 16'd0;
      env_stage      = ST_ATTACK;
      env_volume     = 16'd0;
      env_released   = 1'b0;
      env_active     = 1'b0;
      attack_step    = ATTACK_STEP_RST[15:0];
      decay_factor   = DECAY_FACTOR_RST[15:0];
      sustain_level  = SUSTAIN_LEVEL_RST[15:0];
      release_factor = RELEASE_FACTOR_RST[15:0];
      in_beat_taken <= 1'b0;
    end else begin
      in_beat_taken <= in_ch.valid && in_ch.ready;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ATTACK_STEP:    attack_step    = cfg_wdata;
          CFG_DECAY_FACTOR:   decay_factor   = cfg_wdata;
          CFG_SUSTAIN_LEVEL:  sustain_level  = cfg_wdata;
          CFG_RELEASE_FACTOR: release_factor = cfg_wdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        advance_envelope(in_ch.cmd, in_ch.note_volume);
        beats_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{gain: out_ch.env_gain, stage: out_ch.env_stage,
                active: out_ch.voice_active};
        results_seen++;
        stage_hits[got.stage]++;
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing owed (gain %0d)", got.gain));
        end else begin
          want = results_due[0];
          results_due.delete(0);
          if (got.gain !== want.gain)
            report_mismatch($sformatf("env_gain %0d, model %0d", got.gain, want.gain));
          if (got.stage !== want.stage)
            report_mismatch($sformatf("env_stage %0d, model %0d", got.stage, want.stage));
          if (got.active !== want.active)
            report_mismatch($sformatf("voice_active %0b, model %0b",
                                      got.active, want.active));
        end
      end
    end
  end

  // Command driver: offer the next queued beat once the current one is taken,
  // with random idle bursts between beats.
  always @(negedge clk) begin : drive_cmds
    env_cmd_t next;
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.cmd         <= CMD_TICK;
      in_ch.note_volume <= '0;
      in_gap            <= 0;
    end else if (!in_ch.valid || in_beat_taken) begin
      if (in_gap != 0) begin
        in_ch.valid <= 1'b0;
        in_gap      <= in_gap - 1;
      end else if (pending_cmds.size() != 0) begin
        next = pending_cmds[0];
        pending_cmds.delete(0);
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= next.cmd;
        in_ch.note_volume <= next.volume;
        if ($urandom_range(99) < in_idle_pct)
          in_gap <= $urandom_range(1, 18);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: stall in random bursts, and hold off for good while the
  // squeeze is on.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap      <= 0;
    end else if (long_hold) begin
      out_ch.ready <= 1'b0;
    end else if (out_gap != 0) begin
      out_ch.ready <= 1'b0;
      out_gap      <= out_gap - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(99) < out_idle_pct)
        out_gap <= $urandom_range(1, 18);
    end
  end

  // Squeeze: keep the receiver off long enough that the output register fills
  // and the block stops taking commands while the driver keeps offering.
  initial begin
    @(posedge squeeze_go);
    @(negedge clk);
    long_hold <= 1'b1;
    repeat (LONG_HOLD) @(negedge clk);
    long_hold <= 1'b0;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic push_cmd(logic [CMD_W-1:0] cmd, logic [15:0] volume);
    env_cmd_t entry;
    entry = '{cmd: cmd, volume: volume};
    pending_cmds = {pending_cmds, entry};
    cmds_queued++;
  endtask

  // Hold until every queued beat is taken and every result is back, then let
  // the block settle before the registers change.
  task automatic wait_idle();
    do @(negedge clk);
    while (beats_taken != cmds_queued || results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_regs(logic [15:0] att, logic [15:0] dec, logic [15:0] sus,
                              logic [15:0] rel);
    write_reg(CFG_ATTACK_STEP, att);
    write_reg(CFG_DECAY_FACTOR, dec);
    write_reg(CFG_SUSTAIN_LEVEL, sus);
    write_reg(CFG_RELEASE_FACTOR, rel);
    settings_used++;
  endtask

  // One note with random content: start, a run of ticks, and most of the time
  // a release followed by more ticks so the voice can die out.
  task automatic queue_note_cycle();
    logic [15:0] vol;
    int unsigned n;
    case ($urandom_range(0, 7))
      0:       vol = 16'h0000;
      1:       vol = 16'hFFFF;
      default: vol = 16'($urandom);
    endcase
    push_cmd(CMD_NOTE, vol);
    n = $urandom_range(0, 40);
    repeat (n)
      push_cmd(($urandom_range(0, 19) == 0) ? CMD_UNUSED : CMD_TICK, 16'($urandom));
    if ($urandom_range(0, 3) != 0) begin
      push_cmd(CMD_RELEASE, 16'($urandom));
      n = $urandom_range(0, 30);
      repeat (n)
        push_cmd(($urandom_range(0, 9) == 0) ? CMD_RELEASE : CMD_TICK, 16'($urandom));
    end
  endtask

  initial begin
    int unsigned phase_start;
    logic [15:0] att, dec, sus, rel;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_ATTACK_STEP;
    cfg_wdata         = 16'd0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_TICK;
    in_ch.note_volume = '0;
    out_ch.ready      = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed, register defaults: commands on a silent voice (release sets
    // the flag but nothing moves), a slow attack cut short by a release, and a
    // zero-volume note that runs straight through to sustain.
    @(posedge clk);
    in_idle_pct  = 20;
    out_idle_pct = 20;
    push_cmd(CMD_TICK,    16'h0000);
    push_cmd(CMD_UNUSED,  16'hFFFF);
    push_cmd(CMD_RELEASE, 16'h5555);
    push_cmd(CMD_TICK,    16'hAAAA);
    push_cmd(CMD_NOTE,    16'hFFFF);
    push_cmd(CMD_TICK,    16'h0000);
    push_cmd(CMD_TICK,    16'hFFFF);
    push_cmd(CMD_RELEASE, 16'h0000);
    push_cmd(CMD_TICK,    16'h0000);
    push_cmd(CMD_NOTE,    16'h0000);
    push_cmd(CMD_TICK,    16'h0000);
    push_cmd(CMD_TICK,    16'h0000);
    push_cmd(CMD_TICK,    16'h0000);
    wait_idle();

    // Directed, full-scale attack, zero sustain: leave the voice part way
    // through decay.
    program_regs(16'hFFFF, 16'h8000, 16'h0000, 16'h0000);
    @(posedge clk);
    push_cmd(CMD_NOTE, 16'h8000);
    push_cmd(CMD_TICK, 16'h0000);
    push_cmd(CMD_TICK, 16'h0000);
    push_cmd(CMD_TICK, 16'h0000);
    wait_idle();

    // Raise sustain so the decaying gain sits under its goal, then kill the
    // voice with a zero release factor and poke it while silent.
    write_reg(CFG_SUSTAIN_LEVEL, 16'hFFFF);
    settings_used++;
    @(posedge clk);
    push_cmd(CMD_TICK,    16'h0000);
    push_cmd(CMD_TICK,    16'h0000);
    push_cmd(CMD_RELEASE, 16'h0000);
    push_cmd(CMD_TICK,    16'h0000);
    push_cmd(CMD_NOTE,    16'h1234);
    wait_idle();

    // Random phases: a fresh register setting each, mostly well-formed notes
    // with some stray commands mixed in.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      if (phase == 0) begin
        att = 16'hFFFF; dec = 16'hFFFF; sus = 16'hFFFF; rel = 16'hFFFF;
      end else if (phase == 1) begin
        att = 16'h0000; dec = 16'h0000; sus = 16'h0000; rel = 16'h0000;
      end else begin
        att = pick_setting(1500, 65535);
        dec = pick_setting(0, 62000);
        sus = pick_setting(0, 65535);
        rel = pick_setting(0, 60000);
      end
      program_regs(att, dec, sus, rel);
      @(posedge clk);
      if (phase == RAND_PHASES - 1 || phase == 3) begin
        in_idle_pct  = 0;
        out_idle_pct = (phase == 3) ? 20 : 0;
      end else begin
        in_idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
        out_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
      end
      phase_start = cmds_queued;
      while (cmds_queued - phase_start < PHASE_BEATS) begin
        if ($urandom_range(0, 9) == 0)
          push_cmd(CMD_W'($urandom_range(0, 3)), 16'($urandom));
        else
          queue_note_cycle();
      end
      if (phase == 3)
        squeeze_go = 1'b1;
      wait_idle();
    end

    $display("covered %0d command beats, %0d results, %0d register settings",
             beats_taken, results_seen, settings_used);
    $display("notes %0d, releases %0d, voices ended %0d, stage mix a/d/s/r %0d/%0d/%0d/%0d",
             notes_started, releases_sent, voices_ended,
             stage_hits[0], stage_hits[1], stage_hits[2], stage_hits[3]);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
